>>> hdl/sab_pkg.sv
// Shared constants and types for the six-axis biquad low-pass filter.
package sab_pkg;

	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 30;
	localparam int PHASE_W   = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_B0 = 2'd0,
		CFG_A1 = 2'd1,
		CFG_A2 = 2'd2
	} cfg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PHASE_FIRST  = 2'd0,
		PHASE_SECOND = 2'd1,
		PHASE_STEADY = 2'd2
	} phase_t;

	localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd3888751;
	localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd1957103773;
	localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd898916950;

endpackage

>>> hdl/sab_in_if.sv
// Input channel: start-up phase plus one raw sample per axis, lanes packed low first.
interface sab_in_if #(
	parameter int AXES        = 6,
	parameter int SAMPLE_BITS = 24
);
	logic                               valid;
	logic                               ready;
	logic [sab_pkg::PHASE_W-1:0]        startup_phase;
	logic [AXES*SAMPLE_BITS-1:0]        axis_in;

	modport source (output valid, startup_phase, axis_in, input ready);
	modport sink   (input valid, startup_phase, axis_in, output ready);
endinterface

>>> hdl/sab_out_if.sv
// Output channel: one filtered sample per axis, lanes packed low first.
interface sab_out_if #(
	parameter int AXES        = 6,
	parameter int SAMPLE_BITS = 24
);
	logic                        valid;
	logic                        ready;
	logic [AXES*SAMPLE_BITS-1:0] axis_out;

	modport source (output valid, axis_out, input ready);
	modport sink   (input valid, axis_out, output ready);
endinterface

>>> hdl/six_axis_biquad_lowpass.sv
// Six-axis second-order low-pass (direct form I biquad), one independent filter per axis
// with shared Q2.30 coefficients b0, a1, a2: y = b0*(x + 2*x1 + x2) - a1*y1 - a2*y2, rounded
// half up to an integer and saturated to the sample range. Start-up phase 0 keeps only b0*x,
// phase 1 drops the x2/y2 terms, phase 2 (and the unused code 3) runs the full recurrence.
// Throughput is one beat per cycle while the output is not stalled. An accepted beat sits
// in the input register, and its result moves into the result register once that register
// is free and is offered from there. Back-to-back beats are possible because each
// beat's result is written into the y1 history at the same edge it is written to the result
// register, so the next beat sitting in the input register sees it at once. Per axis the
// datapath is three multipliers (b0 times the summed input taps, a1*y1, a2*y2) feeding one
// add and a saturate.
// Each axis occupies bits [a*SAMPLE_BITS +: SAMPLE_BITS] of axis_in / axis_out. History is
// cleared by reset; coefficient writes are meant to happen only while the block is idle.
module six_axis_biquad_lowpass #(
	parameter int AXES        = 6,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sab_pkg::COEF_W-1:0]        cfg_wdata,
	sab_in_if.sink                            samples,
	sab_out_if.source                         filtered
);

	localparam int SB      = SAMPLE_BITS;
	localparam int CW      = sab_pkg::COEF_W;
	localparam int FB      = sab_pkg::FRAC_BITS;
	localparam int SUM_W   = SB + 2;              // x + 2*x1 + x2
	localparam int FF_W    = CW + SUM_W;
	localparam int FBK_W   = CW + SB;
	localparam int ACC_W   = CW + SB + 4;
	localparam int TOP_W   = ACC_W - (FB + SB - 1); // bits that must all agree to fit

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FB - 1);
	localparam logic [SB-1:0] Y_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] Y_MIN = {1'b1, {(SB-1){1'b0}}};

	// coefficients
	logic signed [CW-1:0] b0_q, a1_q, a2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= sab_pkg::B0_RESET;
			a1_q <= sab_pkg::A1_RESET;
			a2_q <= sab_pkg::A2_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sab_pkg::CFG_B0: b0_q <= cfg_wdata;
				sab_pkg::CFG_A1: a1_q <= cfg_wdata;
				sab_pkg::CFG_A2: a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: result register frees when empty or being taken
	logic valid_s1;
	logic out_valid_q;
	logic adv;
	logic move;
	logic in_ready;

	assign adv      = !out_valid_q || filtered.ready;
	assign in_ready = !valid_s1 || adv;
	assign move     = valid_s1 && adv;
	assign samples.ready = in_ready;

	// input register
	logic [sab_pkg::PHASE_W-1:0] phase_s1;
	logic [AXES*SB-1:0]          x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && in_ready) begin
			phase_s1 <= samples.startup_phase;
			x_s1     <= samples.axis_in;
		end
	end

	// phase decode: code 3 behaves as steady running
	logic use_one;
	logic use_two;

	assign use_one = (phase_s1 != sab_pkg::PHASE_FIRST);
	assign use_two = (phase_s1 != sab_pkg::PHASE_FIRST) && (phase_s1 != sab_pkg::PHASE_SECOND);

	// per-axis history
	logic signed [SB-1:0] x1_q [AXES];
	logic signed [SB-1:0] x2_q [AXES];
	logic signed [SB-1:0] y1_q [AXES];
	logic signed [SB-1:0] y2_q [AXES];
	logic [AXES*SB-1:0]   y_new;
	logic [AXES*SB-1:0]   y_q;

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [SB-1:0]    x_cur;
		logic signed [SUM_W-1:0] tap_sum;
		logic signed [SB-1:0]    y1_m;
		logic signed [SB-1:0]    y2_m;
		logic signed [FF_W-1:0]  prod_ff;
		logic signed [FBK_W-1:0] prod_fb1;
		logic signed [FBK_W-1:0] prod_fb2;
		logic signed [ACC_W-1:0] acc;
		logic [TOP_W-1:0]        acc_top;
		logic [SB-1:0]           y_sat;

		assign x_cur = x_s1[a*SB +: SB];

		always_comb begin
			tap_sum = SUM_W'(x_cur);
			if (use_one) begin
				tap_sum = tap_sum + (SUM_W'(x1_q[a]) <<< 1);
			end
			if (use_two) begin
				tap_sum = tap_sum + SUM_W'(x2_q[a]);
			end
		end

		assign y1_m = use_one ? y1_q[a] : '0;
		assign y2_m = use_two ? y2_q[a] : '0;

		assign prod_ff  = b0_q * tap_sum;
		assign prod_fb1 = a1_q * y1_m;
		assign prod_fb2 = a2_q * y2_m;

		assign acc = ACC_W'(prod_ff) - ACC_W'(prod_fb1) - ACC_W'(prod_fb2) + RND_HALF;
		assign acc_top = acc[ACC_W-1 -: TOP_W];

		// floor of acc / 2^FB, saturated
		always_comb begin
			if ((acc_top == '0) || (acc_top == '1)) begin
				y_sat = acc[FB +: SB];
			end else if (acc[ACC_W-1]) begin
				y_sat = Y_MIN;
			end else begin
				y_sat = Y_MAX;
			end
		end

		assign y_new[a*SB +: SB] = y_sat;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				x1_q[a] <= '0;
				x2_q[a] <= '0;
				y1_q[a] <= '0;
				y2_q[a] <= '0;
			end else if (move) begin
				if (use_one) begin
					x2_q[a] <= x1_q[a];
					y2_q[a] <= y1_q[a];
				end
				x1_q[a] <= x_cur;
				y1_q[a] <= y_sat;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			y_q <= y_new;
		end
	end

	assign filtered.valid    = out_valid_q;
	assign filtered.axis_out = y_q;

`ifndef ASSERT_OFF
	// the stored one-step-old output is exactly what was delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		move |=> (y1_q[0] == y_q[SB-1:0]))
		else $error("y1 history does not match delivered result");

	// input side only stalls when both stages hold a beat and the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !filtered.ready))
		else $error("input stalled without a full pipeline");

	// a first-sample beat leaves the two-step-old history alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(move && !use_one) |=> ($stable(x2_q[0]) && $stable(y2_q[0])))
		else $error("older history changed on a first-sample beat");

	// a beat in the input register reaches the result register when it is free
	assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q)
		else $error("beat lost between input and result register");
`endif

endmodule

>>> tb/sv/six_axis_biquad_lowpass_tb.sv
// Self-checking testbench for the six-axis biquad low-pass filter.
`timescale 1ns / 1ps

module six_axis_biquad_lowpass_tb;

	localparam int AXES        = 6;
	localparam int SAMPLE_BITS = 24;
	localparam int LANES_W     = AXES * SAMPLE_BITS;

	// Unused phase code; the block runs it like steady state.
	localparam logic [sab_pkg::PHASE_W-1:0] PHASE_SPARE = 2'd3;
	// Register index past the end of the list; writes to it are dropped.
	localparam logic [sab_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam longint HALF_LSB = 64'sd1 <<< (sab_pkg::FRAC_BITS - 1);

	// Pipeline of input and result registers, plus margin.
	localparam int SETTLE_CYCLES = 6;
	// Watchdog limit; allow plenty of headroom over the slowest legal run.
	localparam int LIMIT_CYCLES  = 500000;
	localparam int MAX_REPORTS   = 10;

	typedef logic [LANES_W-1:0] lanes_t;

	typedef struct packed {
		logic [sab_pkg::PHASE_W-1:0] phase;
		lanes_t                      lanes;
	} sample_beat_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [sab_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sab_pkg::COEF_W-1:0]    cfg_wdata;

	sab_in_if  #(.AXES(AXES), .SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	sab_out_if #(.AXES(AXES), .SAMPLE_BITS(SAMPLE_BITS)) filter_ch ();

	six_axis_biquad_lowpass #(
		.AXES       (AXES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples  (sample_ch),
		.filtered (filter_ch)
	);

	// ------------------------------------------------------------------
	// Filter model state: coefficient copies and per-axis history.
	// ------------------------------------------------------------------
	logic signed [sab_pkg::COEF_W-1:0] gain_b0 = sab_pkg::B0_RESET;
	logic signed [sab_pkg::COEF_W-1:0] fb_a1   = sab_pkg::A1_RESET;
	logic signed [sab_pkg::COEF_W-1:0] fb_a2   = sab_pkg::A2_RESET;

	longint x_hist1 [AXES];
	longint x_hist2 [AXES];
	longint y_hist1 [AXES];
	longint y_hist2 [AXES];

	sample_beat_t pending_beats [$];
	lanes_t       expected_lanes [$];

	int beats_queued;
	int beats_taken;
	int mismatches;
	int cycle_count;

	// Sender burst/gap bookkeeping.
	int burst_left;
	int gap_left;

	// Receiver stall pattern.
	rx_mode_t rx_mode;
	int       rx_left;

	always #5 clk = ~clk;

	// One beat through all six filters. Exact Q.30 sum, round half up,
	// saturate; history shifts unless this is the first sample.
	function automatic lanes_t filter_beat(input logic [sab_pkg::PHASE_W-1:0] ph,
		input lanes_t xs);
		lanes_t result;
		longint x;
		longint acc;
		longint y;
		longint b0;
		longint a1;
		longint a2;
		b0 = longint'(gain_b0);
		a1 = longint'(fb_a1);
		a2 = longint'(fb_a2);
		for (int a = 0; a < AXES; a++) begin
			x = longint'($signed(xs[a*SAMPLE_BITS +: SAMPLE_BITS]));
			acc = b0 * x;
			if (ph != sab_pkg::PHASE_FIRST) begin
				acc += 2 * b0 * x_hist1[a] - a1 * y_hist1[a];
			end
			if (ph != sab_pkg::PHASE_FIRST && ph != sab_pkg::PHASE_SECOND) begin
				acc += b0 * x_hist2[a] - a2 * y_hist2[a];
			end
			y = (acc + HALF_LSB) >>> sab_pkg::FRAC_BITS;
			if (y > OUT_MAX) y = OUT_MAX;
			if (y < OUT_MIN) y = OUT_MIN;
			// first sample only loads the one-step-old taps
			if (ph != sab_pkg::PHASE_FIRST) begin
				x_hist2[a] = x_hist1[a];
				y_hist2[a] = y_hist1[a];
			end
			x_hist1[a] = x;
			y_hist1[a] = y;
			result[a*SAMPLE_BITS +: SAMPLE_BITS] = y[SAMPLE_BITS-1:0];
		end
		return result;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: begin
				v = int'($urandom_range(0, 2000)) - 1000;
				return v[SAMPLE_BITS-1:0];
			end
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic lanes_t pick_lanes();
		lanes_t l;
		for (int a = 0; a < AXES; a++) begin
			l[a*SAMPLE_BITS +: SAMPLE_BITS] = pick_sample();
		end
		return l;
	endfunction

	function automatic void push_beat(input logic [sab_pkg::PHASE_W-1:0] ph, input lanes_t l);
		pending_beats.push_back('{phase: ph, lanes: l});
		beats_queued++;
	endfunction

	// Random traffic: mostly well-formed start-ups (first, second, then a
	// steady run), some with held lanes so the filters settle; the rest are
	// stray beats with any phase code.
	task automatic queue_random(input int count);
		int     n;
		int     run;
		bit     hold;
		lanes_t l;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 4) == 0) begin
				push_beat(sab_pkg::PHASE_W'($urandom_range(0, 3)), pick_lanes());
				n++;
			end else begin
				hold = 1'($urandom_range(0, 1));
				l = pick_lanes();
				push_beat(sab_pkg::PHASE_FIRST, l);
				if (!hold) l = pick_lanes();
				push_beat(sab_pkg::PHASE_SECOND, l);
				n += 2;
				run = $urandom_range(1, 30);
				for (int k = 0; k < run; k++) begin
					if (!hold || $urandom_range(0, 15) == 0) l = pick_lanes();
					push_beat(($urandom_range(0, 7) == 0) ? PHASE_SPARE
						: sab_pkg::PHASE_STEADY, l);
					n++;
				end
			end
		end
	endtask

	// Block until every queued beat went in and every result came back,
	// then let the pipeline settle before touching registers.
	task automatic wait_idle();
		do @(posedge clk);
		while (beats_taken != beats_queued || expected_lanes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three coefficients back to back, optionally followed by a
	// write to the unused index, which must leave them alone.
	task automatic load_coefs(
		input logic [sab_pkg::COEF_W-1:0] b0,
		input logic [sab_pkg::COEF_W-1:0] a1,
		input logic [sab_pkg::COEF_W-1:0] a2,
		input bit                         stray_write
	);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sab_pkg::CFG_B0;
		cfg_wdata <= b0;
		gain_b0 = b0;
		@(posedge clk);
		cfg_index <= sab_pkg::CFG_A1;
		cfg_wdata <= a1;
		fb_a1 = a1;
		@(posedge clk);
		cfg_index <= sab_pkg::CFG_A2;
		cfg_wdata <= a2;
		fb_a2 = a2;
		if (stray_write) begin
			@(posedge clk);
			cfg_index <= CFG_SPARE;
			cfg_wdata <= $urandom;
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Driver: pulls beats off the pending queue in bursts with random gaps.
	// A beat holds until ready; valid only drops when nothing is queued or
	// a gap is running.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_beat_t b;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (sample_ch.valid && !sample_ch.ready) begin
			// stalled, keep the beat on the bus
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			sample_ch.valid <= 1'b0;
		end else if (pending_beats.size() != 0) begin
			b = pending_beats.pop_front();
			sample_ch.valid <= 1'b1;
			sample_ch.startup_phase <= b.phase;
			sample_ch.axis_in <= b.lanes;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				// about a third of the bursts run straight into the next one
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			sample_ch.valid <= 1'b0;
		end
	end

	// Receiver: ready follows a mode that is redrawn after a random hold.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     filter_ch.ready <= 1'b1;
			RX_COIN:     filter_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   filter_ch.ready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: filter_ch.ready <= cycle_count[2];
			default:     filter_ch.ready <= 1'b1;
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result beat against the oldest expectation, and
	// runs the filter model on every accepted sample beat. Values read here
	// are the ones held across the edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		lanes_t want;
		lanes_t got;
		if (arst_n && filter_ch.valid && filter_ch.ready) begin
			got = filter_ch.axis_out;
			if (expected_lanes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result beat %h", got);
				end
			end else begin
				want = expected_lanes.pop_front();
				for (int a = 0; a < AXES; a++) begin
					if (got[a*SAMPLE_BITS +: SAMPLE_BITS]
							!== want[a*SAMPLE_BITS +: SAMPLE_BITS]) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("axis%0d: expected %0d, got %0d", a,
								$signed(want[a*SAMPLE_BITS +: SAMPLE_BITS]),
								$signed(got[a*SAMPLE_BITS +: SAMPLE_BITS]));
						end
					end
				end
			end
		end
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			expected_lanes.push_back(filter_beat(sample_ch.startup_phase, sample_ch.axis_in));
			beats_taken++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence: one coefficient setting per stage, stimulus queued
	// after the writes land, drained before the next setting.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = sab_pkg::CFG_B0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.startup_phase = sab_pkg::PHASE_FIRST;
		sample_ch.axis_in = '0;
		filter_ch.ready = 1'b0;
		beats_queued = 0;
		beats_taken = 0;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 1;
		gap_left = 0;
		rx_mode = RX_OPEN;
		rx_left = 0;
		for (int a = 0; a < AXES; a++) begin
			x_hist1[a] = 0;
			x_hist2[a] = 0;
			y_hist1[a] = 0;
			y_hist2[a] = 0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: full-scale and patterned lanes through every phase code,
		// starting from cleared history.
		push_beat(sab_pkg::PHASE_FIRST, {AXES{SAMPLE_MAX}});
		push_beat(sab_pkg::PHASE_SECOND, {AXES{SAMPLE_MIN}});
		push_beat(sab_pkg::PHASE_STEADY, {24'h555555, 24'hAAAAAA, 24'h000001,
			24'hFFFFFF, SAMPLE_MIN, SAMPLE_MAX});
		push_beat(PHASE_SPARE, {24'hAAAAAA, 24'h555555, SAMPLE_MAX,
			SAMPLE_MIN, 24'h000000, 24'hFFFFFF});
		push_beat(sab_pkg::PHASE_STEADY, '0);
		queue_random(150);
		wait_idle();

		// Largest gains with feedback of the worst sign: both saturation rails.
		load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		push_beat(sab_pkg::PHASE_FIRST, {AXES{SAMPLE_MAX}});
		push_beat(sab_pkg::PHASE_SECOND, {AXES{SAMPLE_MIN}});
		push_beat(sab_pkg::PHASE_STEADY, {AXES{SAMPLE_MAX}});
		push_beat(PHASE_SPARE, {AXES{SAMPLE_MIN}});
		queue_random(120);
		wait_idle();

		// Opposite extremes, then a write to the unused index.
		load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		queue_random(120);
		wait_idle();

		// b0 = +0.5, no feedback: odd samples land exactly on a half and
		// must round up, negative ones included.
		load_coefs(32'h2000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		push_beat(sab_pkg::PHASE_FIRST, {24'h000001, 24'hFFFFFF, 24'h000003,
			24'hFFFFFD, SAMPLE_MAX, SAMPLE_MIN});
		push_beat(sab_pkg::PHASE_FIRST, {24'hFFFFFF, 24'h000001, 24'hFFFFFD,
			24'h000003, SAMPLE_MIN, SAMPLE_MAX});
		push_beat(sab_pkg::PHASE_SECOND, {AXES{24'h000001}});
		push_beat(sab_pkg::PHASE_STEADY, {AXES{24'hFFFFFF}});
		queue_random(100);
		wait_idle();

		// b0 = -0.5: ties on the other sign.
		load_coefs(32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_random(100);
		wait_idle();

		// Unity feedforward, so the output is the FIR sum of the taps.
		load_coefs(32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_random(80);
		wait_idle();

		// Arbitrary coefficients over the full register range.
		repeat (2) begin
			load_coefs($urandom, $urandom, $urandom, 1'b1);
			queue_random(110);
			wait_idle();
		end

		// Low-pass-style coefficients near the reset design, with random detail.
		load_coefs($urandom_range(1, 1 << 26),
			-32'sd1073741824 - $signed($urandom_range(0, 1 << 29)),
			$urandom_range(1 << 28, 1 << 29), 1'b0);
		queue_random(110);
		wait_idle();

		// Back to the reset values, written explicitly.
		load_coefs(sab_pkg::B0_RESET, sab_pkg::A1_RESET, sab_pkg::A2_RESET, 1'b1);
		queue_random(100);
		wait_idle();

		if (mismatches == 0 && expected_lanes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
